@@ hdl/sptfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sptfp_pkg
// Shared types, constants and the arctangent table for the scan point core.
// ----------------------------------------------------------------------------
package sptfp_pkg;

  // Angle precision kept from the 24-bit turn and number of CORDIC rotations
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_ITERS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                 : ATAN_ENTRIES;

  // Quotient bits of the division by the squared quaternion norm
  localparam int QUO_BITS = 20;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // Configuration register indexes
  localparam logic [7:0] REG_ROT_QUAT    = 8'd0;
  localparam logic [7:0] REG_SHIFT_X     = 8'd1;
  localparam logic [7:0] REG_SHIFT_Y     = 8'd2;
  localparam logic [7:0] REG_SHIFT_Z     = 8'd3;
  localparam logic [7:0] REG_ANGLE_START = 8'd4;
  localparam logic [7:0] REG_ANGLE_STEP  = 8'd5;

  localparam logic [63:0] ROT_QUAT_RESET = 64'h4000_0000_0000_0000;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  // Mask that keeps the top ANGLE_BITS of a 24-bit turn
  localparam logic [23:0] ANGLE_KEEP = ~24'((32'd1 << (24 - ANGLE_BITS)) - 32'd1);

  // Word passed from front to back
  typedef struct packed {
    logic [15:0] theta;
    logic [15:0] range_mm;
    logic        scan_end;
  } sample_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [31:0] atan_turn32(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sh20000000;
      5'd1:  v = 32'sh12E4051E;
      5'd2:  v = 32'sh09FB385B;
      5'd3:  v = 32'sh051111D4;
      5'd4:  v = 32'sh028B0D43;
      5'd5:  v = 32'sh0145D7E1;
      5'd6:  v = 32'sh00A2F61E;
      5'd7:  v = 32'sh00517C55;
      5'd8:  v = 32'sh0028BE53;
      5'd9:  v = 32'sh00145F2F;
      5'd10: v = 32'sh000A2F98;
      5'd11: v = 32'sh000517CC;
      5'd12: v = 32'sh00028BE6;
      5'd13: v = 32'sh000145F3;
      5'd14: v = 32'sh0000A2FA;
      5'd15: v = 32'sh0000517D;
      5'd16: v = 32'sh000028BE;
      5'd17: v = 32'sh0000145F;
      5'd18: v = 32'sh00000A30;
      5'd19: v = 32'sh00000518;
      5'd20: v = 32'sh0000028C;
      5'd21: v = 32'sh00000146;
      5'd22: v = 32'sh000000A3;
      5'd23: v = 32'sh00000051;
      default: v = 32'sh0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/scan_polar_to_frame_points_core.sv @@
// ----------------------------------------------------------------------------
// scan_polar_to_frame_points_core
// Laser range sample to 3-D point in the base frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per range sample, in_tdata[15:0] = range in mm,
//           in_tlast marks the last sample of a scan (index restarts).
//   out_* : one word per sample, x/y/z signed 18-bit mm, out_tlast copies
//           the scan end flag.
//   cfg_* : register writes (index, 64-bit data), always ready; write only
//           while the block is idle.
// Processing: a sample passes through the queue, CORDIC_STAGES (16) CORDIC
//   rotations, the quadrant step, 12 + 1 + 6 steps around the one shared
//   multiplier, three serial divisions and the output register. One sample
//   is worked at a time; a two-word queue lets the input be taken while the
//   back end is busy.
// Reset: rst_n low clears the sample index, the queue and output valid and
//   loads identity rotation, zero shift and zero angles.
// Stall: a held output word is kept; the back end waits for it to be taken
//   and the queue then fills, dropping in_tready.
// ----------------------------------------------------------------------------
module scan_polar_to_frame_points_core import sptfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] range_mm
  input  logic        in_tlast,    // scan_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [17:0] point_x, [35:18] point_y,
                                   // [53:36] point_z, [55:54] zero
  output logic        out_tlast,   // last_point
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] rot_quat_r;
  logic [15:0] shift_x_r, shift_y_r, shift_z_r;
  logic [15:0] angle_start_r, angle_step_r;

  logic    q_push, q_pop, q_full, q_ne;
  sample_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_quat_r    <= ROT_QUAT_RESET;
      shift_x_r     <= '0;
      shift_y_r     <= '0;
      shift_z_r     <= '0;
      angle_start_r <= '0;
      angle_step_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROT_QUAT:    rot_quat_r    <= cfg_data;
        REG_SHIFT_X:     shift_x_r     <= cfg_data[15:0];
        REG_SHIFT_Y:     shift_y_r     <= cfg_data[15:0];
        REG_SHIFT_Z:     shift_z_r     <= cfg_data[15:0];
        REG_ANGLE_START: angle_start_r <= cfg_data[15:0];
        REG_ANGLE_STEP:  angle_step_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  sptfp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .angle_start (angle_start_r),
    .angle_step  (angle_step_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  sptfp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_ne)
  );

  sptfp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_ne),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .rotation_quat (rot_quat_r),
    .shift_x       (shift_x_r),
    .shift_y       (shift_y_r),
    .shift_z       (shift_z_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

endmodule

@@ hdl/sptfp_front.sv @@
// ----------------------------------------------------------------------------
// sptfp_front
// Accepts range samples, assigns the beam angle and keeps the sample index.
// ----------------------------------------------------------------------------
module sptfp_front import sptfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] range_mm
  input  logic        in_tlast,    // scan_end
  input  logic [15:0] angle_start,
  input  logic [15:0] angle_step,
  input  logic        q_full,
  output logic        q_push,
  output sample_t     q_wdata
);

  logic [15:0] idx_r;
  logic [15:0] idx_nxt;
  logic [31:0] ang_prod;

  // Beam angle: start plus index times step, modulo one turn
  assign ang_prod  = idx_r * angle_step;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_wdata.theta    = angle_start + ang_prod[15:0];
    q_wdata.range_mm = in_tdata;
    q_wdata.scan_end = in_tlast;
    idx_nxt          = in_tlast ? 16'd0 : idx_r + 16'd1;
  end

  // Advance the index on each accepted word, restart after scan end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 16'd0;
    end else if (q_push) begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ hdl/sptfp_fifo.sv @@
// ----------------------------------------------------------------------------
// sptfp_fifo
// Short queue of samples between the front and the back.
// ----------------------------------------------------------------------------
module sptfp_fifo import sptfp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  sample_t wdata,
  input  logic    pop,
  output sample_t rdata,
  output logic    full,
  output logic    not_empty
);

  sample_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wp_r;
  logic [QPTR_W-1:0]  rp_r;
  logic [QPTR_W:0]    cnt_r;

  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rp_r];

  // Store words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/sptfp_back.sv @@
// ----------------------------------------------------------------------------
// sptfp_back
// Sequencer: iterative CORDIC, shared multiplier, quaternion rotation,
// bit-serial division by the squared norm and the output register.
// ----------------------------------------------------------------------------
module sptfp_back import sptfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  sample_t     q_rdata,
  output logic        q_pop,
  input  logic [63:0] rotation_quat,
  input  logic [15:0] shift_x,
  input  logic [15:0] shift_y,
  input  logic [15:0] shift_z,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic        out_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROT, ST_QUAD, ST_MUL, ST_MAT, ST_APPLY,
    ST_DLOAD, ST_DRUN, ST_DEND, ST_OUT
  } state_t;

  state_t              state_r;
  logic [4:0]          cnt_r;
  logic [1:0]          axis_r;
  logic [1:0]          quad_r;
  logic [15:0]         range_r;
  logic                last_r;
  logic signed [31:0]  cx_r, cy_r, cz_r;
  logic signed [31:0]  c_r, s_r;
  logic signed [25:0]  px_r, py_r;
  logic signed [31:0]  qp_r [10];
  logic [33:0]         d_r;
  logic signed [35:0]  n_r [6];
  logic signed [62:0]  num_r [3];
  logic                neg_r;
  logic [63:0]         rem_r;
  logic [63:0]         dsh_r;
  logic [QUO_BITS-1:0] quo_r;
  logic signed [17:0]  res_r [3];
  logic                ovalid_r;
  logic [55:0]         odata_r;
  logic                olast_r;

  logic signed [15:0]  qw, qx, qy, qz;
  logic signed [35:0]  mul_a;
  logic signed [25:0]  mul_b;
  logic signed [61:0]  mul_p;
  logic signed [61:0]  px_full;
  logic signed [31:0]  dxs, dys, atan_v;
  logic [23:0]         a24, a24_off;
  logic signed [31:0]  z_init;
  logic signed [33:0]  d_sum;
  logic [33:0]         d_use;
  logic signed [35:0]  d_s;
  logic signed [62:0]  num_sel;
  logic [62:0]         mag;
  logic signed [21:0]  q_s, sum_s;
  logic [15:0]         shift_sel;
  logic signed [17:0]  sat_v;

  assign qw = rotation_quat[63:48];
  assign qx = rotation_quat[47:32];
  assign qy = rotation_quat[31:16];
  assign qz = rotation_quat[15:0];

  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // Angle reduction to the nearest quadrant and the residual
  always_comb begin
    a24     = {q_rdata.theta, 8'd0} & ANGLE_KEEP;
    a24_off = a24 + 24'h200000;
    z_init  = ($signed({10'd0, a24_off[21:0]}) - 32'sh200000) <<< 8;
  end

  // CORDIC stage terms
  always_comb begin
    dxs    = cy_r >>> cnt_r;
    dys    = cx_r >>> cnt_r;
    atan_v = atan_turn32(cnt_r);
  end

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL: begin
        case (cnt_r)
          5'd0:  begin mul_a = 36'(c_r); mul_b = $signed({10'd0, range_r}); end
          5'd1:  begin mul_a = 36'(s_r); mul_b = $signed({10'd0, range_r}); end
          5'd2:  begin mul_a = 36'(qw);  mul_b = 26'(qw); end
          5'd3:  begin mul_a = 36'(qx);  mul_b = 26'(qx); end
          5'd4:  begin mul_a = 36'(qy);  mul_b = 26'(qy); end
          5'd5:  begin mul_a = 36'(qz);  mul_b = 26'(qz); end
          5'd6:  begin mul_a = 36'(qx);  mul_b = 26'(qy); end
          5'd7:  begin mul_a = 36'(qw);  mul_b = 26'(qz); end
          5'd8:  begin mul_a = 36'(qx);  mul_b = 26'(qz); end
          5'd9:  begin mul_a = 36'(qw);  mul_b = 26'(qy); end
          5'd10: begin mul_a = 36'(qy);  mul_b = 26'(qz); end
          5'd11: begin mul_a = 36'(qw);  mul_b = 26'(qx); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_APPLY: begin
        mul_a = n_r[cnt_r[2:0]];
        mul_b = cnt_r[0] ? py_r : px_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p   = mul_a * mul_b;
    px_full = (mul_p + 62'sd2097152) >>> 22;
  end

  // Squared norm, identity fallback for a zero quaternion
  always_comb begin
    d_sum = 34'(qp_r[0]) + 34'(qp_r[1]) + 34'(qp_r[2]) + 34'(qp_r[3]);
    d_use = (d_sum == '0) ? 34'h10000000 : d_sum;
    d_s   = $signed({2'b00, d_use});
  end

  // Division set-up and final scaling
  always_comb begin
    num_sel = num_r[axis_r];
    mag     = num_sel[62] ? 63'(-num_sel) : 63'(num_sel);
    q_s     = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
    case (axis_r)
      2'd0:    shift_sel = shift_x;
      2'd1:    shift_sel = shift_y;
      default: shift_sel = shift_z;
    endcase
    sum_s = q_s + 22'($signed(shift_sel));
    if (sum_s > 22'sd131071) begin
      sat_v = 18'sd131071;
    end else if (sum_s < -22'sd131072) begin
      sat_v = -18'sd131072;
    end else begin
      sat_v = sum_s[17:0];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
      axis_r   <= '0;
    end else begin
      if (ovalid_r && out_tready && (state_r != ST_OUT)) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            range_r <= q_rdata.range_mm;
            last_r  <= q_rdata.scan_end;
            quad_r  <= a24_off[23:22];
            cx_r    <= CORDIC_GAIN_Q30;
            cy_r    <= '0;
            cz_r    <= z_init;
            cnt_r   <= '0;
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          // one micro-rotation a cycle
          if (cz_r >= 0) begin
            cx_r <= cx_r - dxs;
            cy_r <= cy_r + dys;
            cz_r <= cz_r - atan_v;
          end else begin
            cx_r <= cx_r + dxs;
            cy_r <= cy_r - dys;
            cz_r <= cz_r + atan_v;
          end
          if (cnt_r == 5'(CORDIC_ITERS - 1)) begin
            state_r <= ST_QUAD;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_QUAD: begin
          case (quad_r)
            2'd0:    begin c_r <= cx_r;  s_r <= cy_r;  end
            2'd1:    begin c_r <= -cy_r; s_r <= cx_r;  end
            2'd2:    begin c_r <= -cx_r; s_r <= -cy_r; end
            default: begin c_r <= cy_r;  s_r <= -cx_r; end
          endcase
          cnt_r   <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          // planar point and quaternion products
          case (cnt_r)
            5'd0:    px_r <= px_full[25:0];
            5'd1:    py_r <= px_full[25:0];
            default: qp_r[4'(cnt_r - 5'd2)] <= mul_p[31:0];
          endcase
          if (cnt_r == 5'd11) begin
            state_r <= ST_MAT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_MAT: begin
          d_r    <= d_use;
          n_r[0] <= d_s - ((36'(qp_r[2]) + 36'(qp_r[3])) <<< 1);
          n_r[1] <= (36'(qp_r[4]) - 36'(qp_r[5])) <<< 1;
          n_r[2] <= (36'(qp_r[4]) + 36'(qp_r[5])) <<< 1;
          n_r[3] <= d_s - ((36'(qp_r[1]) + 36'(qp_r[3])) <<< 1);
          n_r[4] <= (36'(qp_r[6]) - 36'(qp_r[7])) <<< 1;
          n_r[5] <= (36'(qp_r[8]) + 36'(qp_r[9])) <<< 1;
          cnt_r   <= '0;
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          // accumulate matrix row times planar point
          if (cnt_r[0]) begin
            num_r[cnt_r[2:1]] <= num_r[cnt_r[2:1]] + 63'(mul_p);
          end else begin
            num_r[cnt_r[2:1]] <= 63'(mul_p);
          end
          if (cnt_r == 5'd5) begin
            axis_r  <= '0;
            state_r <= ST_DLOAD;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_DLOAD: begin
          // round half away from zero: add half the divisor to the magnitude
          neg_r   <= num_sel[62];
          rem_r   <= 64'(mag) + (64'(d_r) << 7);
          dsh_r   <= 64'(d_r) << (8 + QUO_BITS - 1);
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_DRUN;
        end
        ST_DRUN: begin
          // one quotient bit a cycle
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            quo_r <= {quo_r[QUO_BITS-2:0], 1'b1};
          end else begin
            quo_r <= {quo_r[QUO_BITS-2:0], 1'b0};
          end
          dsh_r <= dsh_r >> 1;
          if (cnt_r == 5'(QUO_BITS - 1)) begin
            state_r <= ST_DEND;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_DEND: begin
          res_r[axis_r] <= sat_v;
          if (axis_r == 2'd2) begin
            state_r <= ST_OUT;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= ST_DLOAD;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!ovalid_r || out_tready) begin
            odata_r  <= {2'b00, res_r[2], res_r[1], res_r[0]};
            olast_r  <= last_r;
            ovalid_r <= 1'b1;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/scan_polar_to_frame_points_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scan_polar_to_frame_points_core_tb
// Streams range samples through the core under a series of rotation, shift
// and angle settings, predicts each point in fixed point and checks every
// output word in order, with random gaps on both streams.
// ----------------------------------------------------------------------------
module scan_polar_to_frame_points_core_tb import sptfp_pkg::*; ();

  typedef struct {
    logic [15:0] range_mm;
    logic        scan_end;
  } sample_word_t;

  typedef struct {
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic signed [17:0] pz;
    logic               last;
  } frame_point_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [63:0] cfg_data;

  // Predictor state
  logic [63:0] quat_q;
  logic [15:0] shx_q, shy_q, shz_q, ang_start_q, ang_step_q, beam_index_q;

  sample_word_t pending_samples[$];
  frame_point_t expected_points[$];
  int  errors;
  int  in_gap, out_gap;
  bit  sending;

  scan_polar_to_frame_points_core uut (.*);

  // Clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint div_half_away(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // Work out the point for one sample and advance the beam index
  function automatic frame_point_t transform_sample(sample_word_t s);
    frame_point_t p;
    logic [15:0] theta;
    logic [23:0] a24, ar;
    logic [1:0]  quad;
    longint z, x, y, nx, c, sn, px, py;
    longint qw, qx, qy, qz, d, den, n00, n01, n10, n11, n20, n21;
    theta = ang_start_q + beam_index_q * ang_step_q;
    a24 = {theta, 8'd0} & ANGLE_KEEP;
    ar = a24 + 24'h200000;
    quad = ar[23:22];
    z = (longint'(ar[21:0]) - 64'sh200000) * 256;
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z -= longint'(atan_turn32(i[4:0]));
      end else begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z += longint'(atan_turn32(i[4:0]));
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; sn = y; end
      2'd1: begin c = -y; sn = x; end
      2'd2: begin c = -x; sn = -y; end
      default: begin c = y; sn = -x; end
    endcase
    px = shr_floor(longint'(s.range_mm) * c + (64'sd1 <<< 21), 22);
    py = shr_floor(longint'(s.range_mm) * sn + (64'sd1 <<< 21), 22);
    qw = longint'($signed(quat_q[63:48]));
    qx = longint'($signed(quat_q[47:32]));
    qy = longint'($signed(quat_q[31:16]));
    qz = longint'($signed(quat_q[15:0]));
    d = qw * qw + qx * qx + qy * qy + qz * qz;
    // zero quaternion falls back to identity
    if (d == 0) begin
      qw = 16384;
      d = 64'sd1 <<< 28;
    end
    n00 = d - 2 * (qy * qy + qz * qz);
    n01 = 2 * (qx * qy - qw * qz);
    n10 = 2 * (qx * qy + qw * qz);
    n11 = d - 2 * (qx * qx + qz * qz);
    n20 = 2 * (qx * qz - qw * qy);
    n21 = 2 * (qy * qz + qw * qx);
    den = d * 256;
    p.px = 18'(clamp18(div_half_away(n00 * px + n01 * py, den) + $signed(shx_q)));
    p.py = 18'(clamp18(div_half_away(n10 * px + n11 * py, den) + $signed(shy_q)));
    p.pz = 18'(clamp18(div_half_away(n20 * px + n21 * py, den) + $signed(shz_q)));
    p.last = s.scan_end;
    beam_index_q = s.scan_end ? 16'd0 : beam_index_q + 16'd1;
    return p;
  endfunction

  // Input driver: hold the word until taken, then draw a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold
    end else begin
      if (in_tvalid)
        expected_points.insert(expected_points.size(),
                               transform_sample('{in_tdata, in_tlast}));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (sending && pending_samples.size() > 0) begin
        sample_word_t w;
        w = pending_samples.pop_front();
        in_tdata <= w.range_mm;
        in_tlast <= w.scan_end;
        in_tvalid <= 1'b1;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        frame_point_t e;
        logic signed [17:0] gx, gy, gz;
        gx = out_tdata[17:0];
        gy = out_tdata[35:18];
        gz = out_tdata[53:36];
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected output word x=%0d y=%0d z=%0d", $time, gx, gy, gz);
          errors++;
        end else begin
          e = expected_points.pop_front();
          if (gx !== e.px) begin
            $display("%0t: x expected %0d actual %0d", $time, e.px, gx); errors++;
          end
          if (gy !== e.py) begin
            $display("%0t: y expected %0d actual %0d", $time, e.py, gy); errors++;
          end
          if (gz !== e.pz) begin
            $display("%0t: z expected %0d actual %0d", $time, e.pz, gz); errors++;
          end
          if (out_tlast !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, out_tlast);
            errors++;
          end
          if (out_tdata[55:54] !== 2'b00) begin
            $display("%0t: pad expected 0 actual %0b", $time, out_tdata[55:54]);
            errors++;
          end
        end
        out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROT_QUAT:    quat_q = val;
      REG_SHIFT_X:     shx_q = val[15:0];
      REG_SHIFT_Y:     shy_q = val[15:0];
      REG_SHIFT_Z:     shz_q = val[15:0];
      REG_ANGLE_START: ang_start_q = val[15:0];
      REG_ANGLE_STEP:  ang_step_q = val[15:0];
      default: ;
    endcase
  endtask

  // Run a batch of queued samples to completion
  task automatic drain_batch();
    sending = 1'b1;
    while (pending_samples.size() > 0 || in_tvalid || expected_points.size() > 0)
      @(posedge clk);
    sending = 1'b0;
    repeat (150) @(posedge clk);
  endtask

  task automatic queue_random(input int n, input int scan_len);
    sample_word_t w;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: w.range_mm = 16'($urandom_range(0, 65535));
        1: w.range_mm = 16'($urandom_range(0, 2000));
        2: w.range_mm = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
        default: w.range_mm = 16'($urandom_range(30000, 65535));
      endcase
      w.scan_end = (scan_len == 0) ? 1'b0 : ($urandom_range(1, scan_len) == 1);
      pending_samples.insert(pending_samples.size(), w);
    end
  endtask

  function automatic logic [63:0] rand_quat();
    logic [63:0] q;
    case ($urandom_range(0, 3))
      0: q = {$urandom, $urandom};
      1: q = {16'($urandom_range(0, 16384)), 16'($urandom_range(0, 4000)),
              16'(-$urandom_range(0, 4000)), 16'($urandom_range(0, 9000))};
      2: q = {$urandom_range(0, 1) ? 16'hC000 : 16'h4000, 48'd0};
      default: q = {16'd0, 16'($urandom), 16'd0, 16'($urandom)};
    endcase
    return q;
  endfunction

  initial begin
    errors = 0;
    sending = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quat_q = ROT_QUAT_RESET;
    {shx_q, shy_q, shz_q, ang_start_q, ang_step_q, beam_index_q} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, range extremes, scan end
    pending_samples.insert(pending_samples.size(), '{16'd0, 1'b0});
    pending_samples.insert(pending_samples.size(), '{16'hFFFF, 1'b0});
    pending_samples.insert(pending_samples.size(), '{16'd1, 1'b1});
    pending_samples.insert(pending_samples.size(), '{16'h8000, 1'b0});
    drain_batch();

    // Quadrant sweep with full-scale shifts and a non-unit quaternion
    write_reg(REG_ANGLE_STEP, 64'd8192);
    write_reg(REG_ANGLE_START, 64'hFFFF);
    write_reg(REG_SHIFT_X, 64'h7FFF);
    write_reg(REG_SHIFT_Y, 64'h8000);
    write_reg(REG_SHIFT_Z, 64'h7FFF);
    write_reg(REG_ROT_QUAT, 64'h2000_1000_F000_0800);
    write_reg(8'd9, 64'hDEAD);
    for (int i = 0; i < 9; i++)
      pending_samples.insert(pending_samples.size(), '{16'hFFFF, i == 8});
    drain_batch();

    // Zero quaternion, extreme quaternion, full-scale angle step
    write_reg(REG_ROT_QUAT, 64'd0);
    write_reg(REG_ANGLE_STEP, 64'hFFFF);
    write_reg(REG_ANGLE_START, 64'd0);
    for (int i = 0; i < 4; i++)
      pending_samples.insert(pending_samples.size(), '{16'hFFFF, 1'b0});
    drain_batch();
    write_reg(REG_ROT_QUAT, 64'h8000_7FFF_8000_7FFF);
    write_reg(REG_SHIFT_X, 64'h8000);
    write_reg(REG_SHIFT_Y, 64'h7FFF);
    write_reg(REG_SHIFT_Z, 64'h8000);
    for (int i = 0; i < 4; i++)
      pending_samples.insert(pending_samples.size(), '{16'hFFFF, i == 3});
    drain_batch();

    // Random phases over fresh settings
    for (int ph = 0; ph < 20; ph++) begin
      write_reg(REG_ROT_QUAT, rand_quat());
      write_reg(REG_SHIFT_X, $urandom_range(0, 1) ? 64'($urandom) : 64'd0);
      write_reg(REG_SHIFT_Y, 64'($urandom_range(0, 65535)));
      write_reg(REG_SHIFT_Z, $urandom_range(0, 1) ? 64'($urandom) : 64'd0);
      write_reg(REG_ANGLE_START, 64'($urandom_range(0, 65535)));
      write_reg(REG_ANGLE_STEP, $urandom_range(0, 1) ? 64'($urandom_range(0, 65535))
                                                      : 64'($urandom_range(0, 64)));
      queue_random(100, (ph % 3 == 0) ? 0 : $urandom_range(2, 40));
      drain_batch();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
